// File: rtl/nbge_pkg.sv
// nbge_pkg: shared types, constants and saturation helpers for the
// n-body gravity Euler step core. No dependencies.
`default_nettype none
package nbge_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_STEP_COUNT = 2'd0;
   localparam logic [1:0] REG_TIME_STEP  = 2'd1;
   localparam logic [1:0] REG_GRAV_CONST = 2'd2;

   localparam logic [9:0]  STEP_COUNT_RST = 10'd20;
   localparam logic [15:0] TIME_STEP_RST  = 16'd328;
   localparam logic [23:0] GRAV_CONST_RST = 24'd65536;

   localparam logic [47:0] U48_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [46:0] F47_MAX = 47'h7FFF_FFFF_FFFF;
   localparam logic [63:0] DV_MAX  = 64'h0000_0002_0000_0000;

   typedef struct packed {
      logic [31:0]      mass;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
   } body_type;

   typedef logic [2:0][47:0] force_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] root;
   } sqrt_rsp_type;

   function automatic logic [47:0] sat48(input logic [48:0] v);
      logic [47:0] r;
      if (v[48] != v[47]) begin
         r = v[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic [35:0] v);
      logic [31:0] r;
      if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
         r = v[31:0];
      end else begin
         r = v[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/nbge_ifs.sv
// nbge_req_if / nbge_rsp_if: valid/ready channels for body load and result.
// No dependencies.
`default_nettype none
interface nbge_req_if;
   logic               valid;
   logic               ready;
   logic        [31:0] mass;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic               last_body;
   modport source (output valid, mass, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   last_body, input ready);
   modport sink   (input valid, mass, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   last_body, output ready);
endinterface

interface nbge_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_pos_x;
   logic signed [31:0] out_pos_y;
   logic signed [31:0] out_pos_z;
   logic signed [31:0] out_vel_x;
   logic signed [31:0] out_vel_y;
   logic signed [31:0] out_vel_z;
   logic               coincident_seen;
   logic               last_out;
   modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
                   out_vel_z, coincident_seen, last_out, input ready);
   modport sink   (input valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
                   out_vel_z, coincident_seen, last_out, output ready);
endinterface
`default_nettype wire

// File: rtl/nbge_div.sv
// nbge_div: restoring 64/32 unsigned divider, one quotient bit per cycle.
// Depends on nbge_pkg.
`default_nettype none
module nbge_div
   import nbge_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   assign shifted = {rem_ff, quo_ff[63]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// File: rtl/nbge_isqrt.sv
// nbge_isqrt: digit-by-digit floor square root of a 64-bit value,
// one root bit per cycle. Depends on nbge_pkg.
`default_nettype none
module nbge_isqrt
   import nbge_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sqrt_req_type req,
   output sqrt_rsp_type      rsp
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [35:0] part;
   logic [35:0] trial;
   logic [35:0] diff;

   assign part  = {rem_ff, rad_ff[63:62]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign diff  = part - trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (part >= trial) begin
            rem_in  = diff[33:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = part[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.root = root_ff;

endmodule
`default_nettype wire

// File: rtl/nbody_gravity_euler_step_core.sv
// nbody_gravity_euler_step_core: top level, sequencer, body and force memories.
// Depends on nbge_pkg, nbge_ifs, nbge_div, nbge_isqrt.
//
// Usage: bodies arrive on req_if, one transaction per cycle while loading
// (mass, position, velocity, Q16.16). The transaction flagged last_body starts
// the run; req_if.ready then stays low until the last result is taken.
// Bodies past MAX_BODIES are dropped. The run executes step_count Euler steps;
// each pair takes three passes of the divider, and the square root overlaps
// the mass product; each body update takes one divide per axis when the body
// mass is nonzero. Results leave on rsp_if in load order, one at a time (the
// next is read only once the last is taken), held while rsp_if.ready is low.
// Registers are written through the APB-style port at byte addresses 0, 4, 8.
// Reset (synchronous) clears the body count and restores register defaults;
// memories hold no reset state and need no clearing pass.
`default_nettype none
module nbody_gravity_euler_step_core
   import nbge_pkg::*;
#(
   parameter int MAX_BODIES = 64
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   nbge_req_if.sink                   req_if,
   nbge_rsp_if.source                 rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int CW = $clog2(MAX_BODIES + 1);

   localparam logic [5:0] ST_LOAD  = 6'd0;
   localparam logic [5:0] ST_STEP  = 6'd1;
   localparam logic [5:0] ST_ROWRD = 6'd2;
   localparam logic [5:0] ST_ROWLD = 6'd3;
   localparam logic [5:0] ST_KRD   = 6'd4;
   localparam logic [5:0] ST_KLD   = 6'd5;
   localparam logic [5:0] ST_SQ    = 6'd6;
   localparam logic [5:0] ST_SQE   = 6'd7;
   localparam logic [5:0] ST_CHK   = 6'd8;
   localparam logic [5:0] ST_MM    = 6'd9;
   localparam logic [5:0] ST_MMR   = 6'd10;
   localparam logic [5:0] ST_G0    = 6'd11;
   localparam logic [5:0] ST_G1    = 6'd12;
   localparam logic [5:0] ST_G2    = 6'd13;
   localparam logic [5:0] ST_SQW   = 6'd14;
   localparam logic [5:0] ST_DS    = 6'd15;
   localparam logic [5:0] ST_DW    = 6'd16;
   localparam logic [5:0] ST_C0    = 6'd17;
   localparam logic [5:0] ST_C1    = 6'd18;
   localparam logic [5:0] ST_C2    = 6'd19;
   localparam logic [5:0] ST_WK    = 6'd20;
   localparam logic [5:0] ST_WQ    = 6'd21;
   localparam logic [5:0] ST_MRD   = 6'd22;
   localparam logic [5:0] ST_MLD   = 6'd23;
   localparam logic [5:0] ST_MA0   = 6'd24;
   localparam logic [5:0] ST_MA1   = 6'd25;
   localparam logic [5:0] ST_MA2   = 6'd26;
   localparam logic [5:0] ST_MDW   = 6'd27;
   localparam logic [5:0] ST_MV    = 6'd28;
   localparam logic [5:0] ST_MP0   = 6'd29;
   localparam logic [5:0] ST_MP1   = 6'd30;
   localparam logic [5:0] ST_MWB   = 6'd31;
   localparam logic [5:0] ST_ORD   = 6'd32;
   localparam logic [5:0] ST_OLD   = 6'd33;
   localparam logic [5:0] ST_OWT   = 6'd34;

   // configuration
   logic [9:0]  step_count_ff;
   logic [15:0] time_step_ff;
   logic [23:0] grav_const_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= STEP_COUNT_RST;
         time_step_ff  <= TIME_STEP_RST;
         grav_const_ff <= GRAV_CONST_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_STEP_COUNT: step_count_ff <= pwdata[9:0];
            REG_TIME_STEP:  time_step_ff  <= pwdata[15:0];
            REG_GRAV_CONST: grav_const_ff <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_STEP_COUNT: prdata = {22'd0, step_count_ff};
         REG_TIME_STEP:  prdata = {16'd0, time_step_ff};
         REG_GRAV_CONST: prdata = {8'd0, grav_const_ff};
         default:        prdata = '0;
      endcase
   end

   // memories
   body_type  body_mem  [MAX_BODIES];
   force_type force_mem [MAX_BODIES];
   body_type  body_rd_ff;
   force_type force_rd_ff;
   logic          body_we, force_we;
   logic [AW-1:0] body_wa, force_wa, rd_addr;
   body_type      body_wd;
   force_type     force_wd;

   always_ff @(posedge clock) begin
      if (body_we) begin
         body_mem[body_wa] <= body_wd;
      end
      body_rd_ff <= body_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (force_we) begin
         force_mem[force_wa] <= force_wd;
      end
      force_rd_ff <= force_mem[rd_addr];
   end

   // arithmetic units
   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   nbge_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   nbge_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   // sequencer registers
   logic [5:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [9:0]       steps_ff, steps_in;
   logic             flag_ff, flag_in;
   logic [AW-1:0]    q_ff, q_in;
   logic [AW-1:0]    k_ff, k_in;
   logic [1:0]       ax_ff, ax_in;
   logic [1:0]       divn_ff, divn_in;
   logic [2:0][31:0] pos_ff, pos_in;
   logic [2:0][31:0] vel_ff, vel_in;
   logic [31:0]      mq_ff, mq_in;
   logic [31:0]      mk_ff, mk_in;
   logic [2:0][31:0] mag_ff, mag_in;
   logic [2:0]       neg_ff, neg_in;
   force_type        fq_ff, fq_in;
   force_type        fk_ff, fk_in;
   logic [63:0]      r2_ff, r2_in;
   logic [47:0]      mm_ff, mm_in;
   logic [63:0]      acc_ff, acc_in;
   logic [47:0]      f_ff, f_in;
   logic [31:0]      dist_ff, dist_in;
   logic [33:0]      dv_ff, dv_in;
   logic [63:0]      mul_ff;
   logic [31:0]      mul_a, mul_b;
   logic             rsp_valid_ff, rsp_valid_in;
   body_type         rsp_body_ff, rsp_body_in;
   logic             rsp_flag_ff, rsp_flag_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_acc;
   logic [2:0][32:0] dk;
   logic [64:0]      r2_sum;
   logic [71:0]      gprod;
   logic [79:0]      cprod;
   logic [46:0]      cmag;
   logic [47:0]      cs;
   logic [47:0]      fmag;
   logic [31:0]      vmag;
   logic [63:0]      mprod;
   logic [35:0]      vsum;
   logic [35:0]      psum;
   logic [63:0]      fquot;

   assign req_acc = req_if.valid & req_if.ready;
   assign req_if.ready = (state_ff == ST_LOAD);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dk[a] = {pos_ff[a][31], pos_ff[a]} - {body_rd_ff.pos[a][31], body_rd_ff.pos[a]};
      end
   end

   assign r2_sum = {1'b0, r2_ff} + {1'b0, mul_ff};
   assign gprod  = {8'd0, acc_ff} + {mul_ff[47:0], 24'd0};
   assign cprod  = {16'd0, acc_ff} + {mul_ff[55:0], 24'd0};
   assign cmag   = (cprod[79:63] != '0) ? F47_MAX : cprod[62:16];
   assign cs     = neg_ff[ax_ff] ? (48'd0 - {1'b0, cmag}) : {1'b0, cmag};
   assign fmag   = fq_ff[ax_ff][47] ? (48'd0 - fq_ff[ax_ff]) : fq_ff[ax_ff];
   assign vmag   = vel_ff[ax_ff][31] ? (32'd0 - vel_ff[ax_ff]) : vel_ff[ax_ff];
   assign mprod  = acc_ff + {mul_ff[39:0], 24'd0};
   assign fquot  = div_rsp.quotient;
   assign vsum   = fq_ff[ax_ff][47]
                   ? ({{4{vel_ff[ax_ff][31]}}, vel_ff[ax_ff]} - {2'b00, dv_ff})
                   : ({{4{vel_ff[ax_ff][31]}}, vel_ff[ax_ff]} + {2'b00, dv_ff});
   assign psum   = vel_ff[ax_ff][31]
                   ? ({{4{pos_ff[ax_ff][31]}}, pos_ff[ax_ff]} - {4'd0, mul_ff[47:16]})
                   : ({{4{pos_ff[ax_ff][31]}}, pos_ff[ax_ff]} + {4'd0, mul_ff[47:16]});

   // shared 32x32 multiplier, registered
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQ:  begin mul_a = mag_ff[ax_ff];           mul_b = mag_ff[ax_ff]; end
         ST_MM:  begin mul_a = mq_ff;                   mul_b = mk_ff; end
         ST_G0:  begin mul_a = {8'd0, mm_ff[23:0]};     mul_b = {8'd0, grav_const_ff}; end
         ST_G1:  begin mul_a = {8'd0, mm_ff[47:24]};    mul_b = {8'd0, grav_const_ff}; end
         ST_C0:  begin mul_a = {8'd0, f_ff[23:0]};      mul_b = mag_ff[ax_ff]; end
         ST_C1:  begin mul_a = {8'd0, f_ff[47:24]};     mul_b = mag_ff[ax_ff]; end
         ST_MA0: begin mul_a = {8'd0, fmag[23:0]};      mul_b = {16'd0, time_step_ff}; end
         ST_MA1: begin mul_a = {8'd0, fmag[47:24]};     mul_b = {16'd0, time_step_ff}; end
         ST_MP0: begin mul_a = vmag;                    mul_b = {16'd0, time_step_ff}; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      steps_in     = steps_ff;
      flag_in      = flag_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      ax_in        = ax_ff;
      divn_in      = divn_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      mq_in        = mq_ff;
      mk_in        = mk_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      fq_in        = fq_ff;
      fk_in        = fk_ff;
      r2_in        = r2_ff;
      mm_in        = mm_ff;
      acc_in       = acc_ff;
      f_in         = f_ff;
      dist_in      = dist_ff;
      dv_in        = dv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_body_in  = rsp_body_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_last_in  = rsp_last_ff;
      body_we      = 1'b0;
      body_wa      = q_ff;
      body_wd      = '{mass: mq_ff, pos: pos_ff, vel: vel_ff};
      force_we     = 1'b0;
      force_wa     = k_ff;
      force_wd     = fk_ff;
      rd_addr      = q_ff;
      div_req      = '{start: 1'b0, dividend: {f_ff, 16'd0}, divisor: dist_ff};
      sqrt_req     = '{start: 1'b0, radicand: r2_ff};

      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (count_ff < CW'(MAX_BODIES)) begin
                  body_we = 1'b1;
                  body_wa = count_ff[AW-1:0];
                  body_wd.mass   = req_if.mass;
                  body_wd.pos[0] = req_if.pos_x;
                  body_wd.pos[1] = req_if.pos_y;
                  body_wd.pos[2] = req_if.pos_z;
                  body_wd.vel[0] = req_if.vel_x;
                  body_wd.vel[1] = req_if.vel_y;
                  body_wd.vel[2] = req_if.vel_z;
                  count_in = count_ff + CW'(1);
               end
               if (req_if.last_body) begin
                  flag_in  = 1'b0;
                  steps_in = '0;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            q_in = '0;
            if (steps_ff == step_count_ff) begin
               state_in = ST_ORD;
            end else if (count_ff >= CW'(2)) begin
               state_in = ST_ROWRD;
            end else begin
               state_in = ST_MRD;
            end
         end
         ST_ROWRD: begin
            rd_addr  = q_ff;
            state_in = ST_ROWLD;
         end
         ST_ROWLD: begin
            pos_in   = body_rd_ff.pos;
            mq_in    = body_rd_ff.mass;
            fq_in    = (q_ff == '0) ? '0 : force_rd_ff;
            k_in     = q_ff + AW'(1);
            state_in = ST_KRD;
         end
         ST_KRD: begin
            rd_addr  = k_ff;
            state_in = ST_KLD;
         end
         ST_KLD: begin
            mk_in = body_rd_ff.mass;
            fk_in = (q_ff == '0) ? '0 : force_rd_ff;
            for (int a = 0; a < 3; a++) begin
               neg_in[a] = dk[a][32];
               mag_in[a] = dk[a][32] ? (32'd0 - dk[a][31:0]) : dk[a][31:0];
            end
            r2_in    = '0;
            ax_in    = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (ax_ff != 2'd0) begin
               r2_in = r2_sum[64] ? '1 : r2_sum[63:0];
            end
            if (ax_ff == 2'd2) begin
               state_in = ST_SQE;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_SQE: begin
            r2_in    = r2_sum[64] ? '1 : r2_sum[63:0];
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (r2_ff == '0) begin
               flag_in  = 1'b1;
               state_in = ST_WK;
            end else begin
               sqrt_req.start = 1'b1;
               state_in = ST_MM;
            end
         end
         ST_MM:  state_in = ST_MMR;
         ST_MMR: begin
            mm_in    = mul_ff[63:16];
            state_in = ST_G0;
         end
         ST_G0:  state_in = ST_G1;
         ST_G1: begin
            acc_in   = mul_ff;
            state_in = ST_G2;
         end
         ST_G2: begin
            f_in     = (gprod[71:64] != '0) ? U48_MAX : gprod[63:16];
            state_in = ST_SQW;
         end
         ST_SQW: begin
            if (!sqrt_rsp.busy) begin
               dist_in  = sqrt_rsp.root;
               divn_in  = '0;
               state_in = ST_DS;
            end
         end
         ST_DS: begin
            div_req.start = 1'b1;
            state_in = ST_DW;
         end
         ST_DW: begin
            if (!div_rsp.busy) begin
               f_in    = (fquot[63:48] != '0) ? U48_MAX : fquot[47:0];
               divn_in = divn_ff + 2'd1;
               if (divn_ff == 2'd2) begin
                  ax_in    = '0;
                  state_in = ST_C0;
               end else begin
                  state_in = ST_DS;
               end
            end
         end
         ST_C0: state_in = ST_C1;
         ST_C1: begin
            acc_in   = mul_ff;
            state_in = ST_C2;
         end
         ST_C2: begin
            fq_in[ax_ff] = sat48({fq_ff[ax_ff][47], fq_ff[ax_ff]} - {cs[47], cs});
            fk_in[ax_ff] = sat48({fk_ff[ax_ff][47], fk_ff[ax_ff]} + {cs[47], cs});
            if (ax_ff == 2'd2) begin
               state_in = ST_WK;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_C0;
            end
         end
         ST_WK: begin
            force_we = 1'b1;
            force_wa = k_ff;
            force_wd = fk_ff;
            if ((CW'(k_ff) + CW'(1)) < count_ff) begin
               k_in     = k_ff + AW'(1);
               state_in = ST_KRD;
            end else begin
               state_in = ST_WQ;
            end
         end
         ST_WQ: begin
            force_we = 1'b1;
            force_wa = q_ff;
            force_wd = fq_ff;
            if ((CW'(q_ff) + CW'(2)) < count_ff) begin
               q_in     = q_ff + AW'(1);
               state_in = ST_ROWRD;
            end else begin
               q_in     = '0;
               state_in = ST_MRD;
            end
         end
         ST_MRD: begin
            rd_addr  = q_ff;
            state_in = ST_MLD;
         end
         ST_MLD: begin
            pos_in   = body_rd_ff.pos;
            vel_in   = body_rd_ff.vel;
            mq_in    = body_rd_ff.mass;
            fq_in    = (count_ff == CW'(1)) ? '0 : force_rd_ff;
            ax_in    = '0;
            state_in = ST_MA0;
         end
         ST_MA0: state_in = ST_MA1;
         ST_MA1: begin
            acc_in   = mul_ff;
            state_in = ST_MA2;
         end
         ST_MA2: begin
            if (mq_ff == '0) begin
               dv_in    = '0;
               state_in = ST_MV;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = mprod;
               div_req.divisor  = mq_ff;
               state_in = ST_MDW;
            end
         end
         ST_MDW: begin
            if (!div_rsp.busy) begin
               dv_in    = (fquot > DV_MAX) ? DV_MAX[33:0] : fquot[33:0];
               state_in = ST_MV;
            end
         end
         ST_MV: begin
            vel_in[ax_ff] = sat32(vsum);
            state_in = ST_MP0;
         end
         ST_MP0: state_in = ST_MP1;
         ST_MP1: begin
            pos_in[ax_ff] = sat32(psum);
            if (ax_ff == 2'd2) begin
               state_in = ST_MWB;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_MA0;
            end
         end
         ST_MWB: begin
            body_we = 1'b1;
            body_wa = q_ff;
            if ((CW'(q_ff) + CW'(1)) < count_ff) begin
               q_in     = q_ff + AW'(1);
               state_in = ST_MRD;
            end else begin
               steps_in = steps_ff + 10'd1;
               state_in = ST_STEP;
            end
         end
         ST_ORD: begin
            rd_addr  = q_ff;
            state_in = ST_OLD;
         end
         ST_OLD: begin
            rsp_body_in  = body_rd_ff;
            rsp_flag_in  = flag_ff;
            rsp_last_in  = ((CW'(q_ff) + CW'(1)) == count_ff);
            rsp_valid_in = 1'b1;
            state_in     = ST_OWT;
         end
         ST_OWT: begin
            if (rsp_if.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  steps_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  q_in     = q_ff + AW'(1);
                  state_in = ST_ORD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         steps_ff     <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff        <= q_in;
      k_ff        <= k_in;
      ax_ff       <= ax_in;
      divn_ff     <= divn_in;
      pos_ff      <= pos_in;
      vel_ff      <= vel_in;
      mq_ff       <= mq_in;
      mk_ff       <= mk_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      fq_ff       <= fq_in;
      fk_ff       <= fk_in;
      r2_ff       <= r2_in;
      mm_ff       <= mm_in;
      acc_ff      <= acc_in;
      f_ff        <= f_in;
      dist_ff     <= dist_in;
      dv_ff       <= dv_in;
      rsp_body_ff <= rsp_body_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.out_pos_x       = rsp_body_ff.pos[0];
   assign rsp_if.out_pos_y       = rsp_body_ff.pos[1];
   assign rsp_if.out_pos_z       = rsp_body_ff.pos[2];
   assign rsp_if.out_vel_x       = rsp_body_ff.vel[0];
   assign rsp_if.out_vel_y       = rsp_body_ff.vel[1];
   assign rsp_if.out_vel_z       = rsp_body_ff.vel[2];
   assign rsp_if.coincident_seen = rsp_flag_ff;
   assign rsp_if.last_out        = rsp_last_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_sqrt_start_idle: assert property (@(posedge clock) disable iff (reset)
      sqrt_req.start |-> !sqrt_rsp.busy)
      else $error("square root started while busy");

   a_reload_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last_out) |=> (req_if.ready && count_ff == '0))
      else $error("block not reloading after last result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> (count_ff <= CW'(MAX_BODIES)))
      else $error("body count beyond capacity");

endmodule
`default_nettype wire

// File: verif/nbge_tb_ifs_note.sv
// Testbench-side helper types for the n-body gravity Euler step core bench.
// Depends on nothing; the channels themselves come from rtl/nbge_ifs.sv.
package nbge_tb_pkg;
   typedef struct {
      logic [31:0] px, py, pz, vx, vy, vz;
      logic        coin;
      logic        last;
   } body_result_type;
endpackage

// File: verif/nbody_gravity_euler_step_core_tb.sv
// Self-checking bench for nbody_gravity_euler_step_core: loads bodies over the
// request channel, predicts final states with an in-bench fixed-point model and
// checks every result transaction. Depends on nbge_pkg, nbge_ifs, nbge_tb_pkg.
module nbody_gravity_euler_step_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nbge_tb_pkg::*;

   localparam int NBODY = 64;
   localparam int ADDR_W = nbge_pkg::CSR_ADDR_W;
   localparam longint unsigned U48M = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint          F48P = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint          F48N = -64'sh0000_8000_0000_0000;
   localparam longint unsigned DVM  = 64'h0000_0002_0000_0000;
   localparam longint unsigned UMAX = 64'hFFFF_FFFF_FFFF_FFFF;

   logic clock = 0;
   logic reset;
   logic psel, penable, pwrite;
   logic [nbge_pkg::CSR_ADDR_W-1:0] paddr;
   logic [nbge_pkg::CSR_DATA_W-1:0] pwdata;
   logic [nbge_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   nbge_req_if req();
   nbge_rsp_if rsp();

   nbody_gravity_euler_step_core i_dut (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // predictor state
   longint unsigned steps_cfg, dt_cfg, g_cfg;
   longint unsigned mass_m[NBODY];
   longint          pos_m[3*NBODY], vel_m[3*NBODY], frc_m[3*NBODY];
   int              loaded;
   bit              coin_flag;
   body_result_type pending_results[$];

   int  errors, items_sent, results_seen, runs_done;
   bit  no_idle, hold_off_req;

   function automatic longint unsigned mag(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clip48(longint v);
      if (v > F48P) return F48P;
      if (v < F48N) return F48N;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned scaled_div(longint unsigned a, longint unsigned d);
      longint unsigned qv;
      qv = (a << 16) / d;
      return qv > U48M ? U48M : qv;
   endfunction

   function automatic void pair_gravity(int q, int k);
      longint          d[3];
      longint unsigned r2, sq, rdist, mm, gmm, f, m, p;
      longint          c;
      r2 = 0;
      for (int a = 0; a < 3; a++) begin
         d[a] = pos_m[3*q+a] - pos_m[3*k+a];
         m = mag(d[a]);
         sq = m * m;
         r2 = (r2 > UMAX - sq) ? UMAX : r2 + sq;
      end
      if (r2 == 0) begin
         coin_flag = 1;
         return;
      end
      rdist = int_sqrt(r2);
      mm = (mass_m[q] * mass_m[k]) >> 16;
      if (g_cfg != 0 && mm > UMAX / g_cfg) gmm = U48M;
      else gmm = (mm * g_cfg) >> 16;
      if (gmm > U48M) gmm = U48M;
      f = scaled_div(gmm, rdist);
      f = scaled_div(f, rdist);
      f = scaled_div(f, rdist);
      for (int a = 0; a < 3; a++) begin
         m = mag(d[a]);
         if (m != 0 && f > UMAX / m) p = UMAX;
         else p = f * m;
         p = p >> 16;
         if (p > F48P) p = F48P;
         c = d[a] < 0 ? -longint'(p) : longint'(p);
         frc_m[3*q+a] = clip48(frc_m[3*q+a] - c);
         frc_m[3*k+a] = clip48(frc_m[3*k+a] + c);
      end
   endfunction

   function automatic void euler_update(int q);
      longint          fr, v;
      longint unsigned dv, dp;
      for (int a = 0; a < 3; a++) begin
         fr = frc_m[3*q+a];
         v = vel_m[3*q+a];
         dv = 0;
         if (mass_m[q] != 0) dv = (mag(fr) * dt_cfg) / mass_m[q];
         if (dv > DVM) dv = DVM;
         v = clip32(fr < 0 ? v - longint'(dv) : v + longint'(dv));
         vel_m[3*q+a] = v;
         dp = (mag(v) * dt_cfg) >> 16;
         pos_m[3*q+a] = clip32(v < 0 ? pos_m[3*q+a] - longint'(dp)
                                     : pos_m[3*q+a] + longint'(dp));
      end
   endfunction

   function automatic void absorb_body(logic [31:0] ms, logic [31:0] p[3],
                                       logic [31:0] v[3], bit last);
      body_result_type r;
      if (loaded < NBODY) begin
         mass_m[loaded] = 64'(ms);
         for (int a = 0; a < 3; a++) begin
            pos_m[3*loaded+a] = longint'(signed'(p[a]));
            vel_m[3*loaded+a] = longint'(signed'(v[a]));
         end
         loaded++;
      end
      if (!last) return;
      coin_flag = 0;
      for (longint unsigned s = 0; s < steps_cfg; s++) begin
         for (int a = 0; a < 3*NBODY; a++) frc_m[a] = 0;
         for (int q = 0; q < loaded; q++)
            for (int k = q + 1; k < loaded; k++) pair_gravity(q, k);
         for (int q = 0; q < loaded; q++) euler_update(q);
      end
      for (int q = 0; q < loaded; q++) begin
         r.px = pos_m[3*q][31:0]; r.py = pos_m[3*q+1][31:0]; r.pz = pos_m[3*q+2][31:0];
         r.vx = vel_m[3*q][31:0]; r.vy = vel_m[3*q+1][31:0]; r.vz = vel_m[3*q+2][31:0];
         r.coin = coin_flag;
         r.last = (q + 1 == loaded);
         pending_results.push_back(r);
      end
      loaded = 0;
      runs_done++;
   endfunction

   function automatic int draw_wait();
      if (no_idle) return 0;
      return $urandom_range(0, 11);
   endfunction

   task automatic send_body(logic [31:0] ms, logic [31:0] p[3], logic [31:0] v[3],
                            bit last);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.mass <= ms;
      req.pos_x <= p[0]; req.pos_y <= p[1]; req.pos_z <= p[2];
      req.vel_x <= v[0]; req.vel_y <= v[1]; req.vel_z <= v[2];
      req.last_body <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      absorb_body(ms, p, v, last);
      items_sent++;
   endtask

   task automatic wait_idle();
      req.valid <= 0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [31:0] value);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= ADDR_W'(idx * 4); pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         nbge_pkg::REG_STEP_COUNT: steps_cfg = 64'(value & 32'h3FF);
         nbge_pkg::REG_TIME_STEP:  dt_cfg = 64'(value & 32'hFFFF);
         nbge_pkg::REG_GRAV_CONST: g_cfg = 64'(value & 32'hFF_FFFF);
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] sc, logic [31:0] dt, logic [31:0] g);
      csr_write(nbge_pkg::REG_STEP_COUNT, sc);
      csr_write(nbge_pkg::REG_TIME_STEP, dt);
      csr_write(nbge_pkg::REG_GRAV_CONST, g);
   endtask

   function automatic logic [31:0] near_val(int span);
      return $urandom_range(0, 1) ? $urandom_range(0, span) : -$urandom_range(0, span);
   endfunction

   task automatic send_random_run(int n, bit wide);
      logic [31:0] ms, p[3], v[3];
      for (int i = 0; i < n; i++) begin
         ms = wide ? $urandom() : $urandom_range(1 << 12, 1 << 20);
         if (ms == 0) ms = 1;
         for (int a = 0; a < 3; a++) begin
            p[a] = wide ? $urandom() : near_val(1 << 20);
            v[a] = wide ? $urandom() : near_val(1 << 17);
         end
         send_body(ms, p, v, i == n - 1);
      end
   endtask

   // default registers, coincident pair, extremes of position and velocity
   task automatic test_reset_defaults();
      logic [31:0] p[3], v[3];
      p = '{32'h0001_0000, 32'h0, 32'h0}; v = '{32'h0, 32'h0, 32'h0};
      send_body(32'h0001_0000, p, v, 0);
      send_body(32'h0002_0000, p, v, 0);
      p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
      send_body(32'hFFFF_FFFF, p, v, 1);
      wait_idle();
   endtask

   task automatic test_single_body_long();
      logic [31:0] p[3], v[3];
      set_config(32'd1023, 32'd65535, 32'd1);
      p = '{32'h0, 32'h8000_0000, 32'h7FFF_0000};
      v = '{32'h0000_1234, 32'hFFFF_0000, 32'h7FFF_FFFF};
      send_body(32'h0000_0001, p, v, 1);
      wait_idle();
   endtask

   // zero mass, max G with wide-value masking, unused register index
   task automatic test_mass_and_gravity_extremes();
      logic [31:0] p[3], v[3];
      set_config(32'hFFFF_FC01, 32'h0001_0001, 32'hFFFF_FFFF);
      csr_write(3, 32'hDEAD_BEEF);
      p = '{32'h0000_0100, 32'h0, 32'h0}; v = '{32'h0, 32'h0, 32'h0};
      send_body(32'h0, p, v, 0);
      p = '{32'h0, 32'h0000_0100, 32'h0};
      send_body(32'hFFFF_FFFF, p, v, 0);
      p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
      send_body(32'hFFFF_FFFF, p, v, 1);
      wait_idle();
      set_config(32'd2, 32'd0, 32'd0);
      send_random_run(3, 0);
      wait_idle();
   endtask

   // zero steps: bodies come back unchanged; the body past the store is dropped
   task automatic test_store_full();
      logic [31:0] ms, p[3], v[3];
      set_config(32'd0, 32'd328, 32'd65536);
      for (int i = 0; i <= NBODY; i++) begin
         ms = $urandom();
         for (int a = 0; a < 3; a++) begin
            p[a] = $urandom(); v[a] = $urandom();
         end
         send_body(ms, p, v, i == NBODY);
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      set_config(32'd1, 32'd4000, 32'd65536);
      hold_off_req = 1;
      send_random_run(6, 0);
      send_random_run(4, 0);
      send_random_run(2, 0);
      wait_idle();
   endtask

   task automatic test_random_runs();
      int n;
      while (items_sent < 310) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            case ($urandom_range(0, 3))
               0: set_config(1, 1, 1);
               1: set_config(3, 65535, 24'hFF_FFFF);
               default: set_config($urandom_range(1, 3), $urandom_range(1, 65535),
                                    $urandom_range(1, 24'hFF_FFFF));
            endcase
         end
         no_idle = ($urandom_range(0, 4) == 0);
         n = $urandom_range(1, 6);
         send_random_run(n, $urandom_range(0, 7) == 0);
      end
      no_idle = 0;
      wait_idle();
   endtask

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   initial begin
      body_result_type e;
      int stall;
      rsp.ready <= 0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = draw_wait();
         if (hold_off_req) begin
            hold_off_req = 0;
            stall = 1500;
         end
         if (stall > 0) begin
            rsp.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result transaction with no expectation pending");
            errors++;
         end else begin
            e = pending_results.pop_front();
            check_field("out_pos_x", e.px, rsp.out_pos_x);
            check_field("out_pos_y", e.py, rsp.out_pos_y);
            check_field("out_pos_z", e.pz, rsp.out_pos_z);
            check_field("out_vel_x", e.vx, rsp.out_vel_x);
            check_field("out_vel_y", e.vy, rsp.out_vel_y);
            check_field("out_vel_z", e.vz, rsp.out_vel_z);
            check_field("coincident_seen", e.coin, rsp.coincident_seen);
            check_field("last_out", e.last, rsp.last_out);
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset <= 1;
      psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
      req.valid <= 0; req.mass <= '0; req.last_body <= 0;
      req.pos_x <= '0; req.pos_y <= '0; req.pos_z <= '0;
      req.vel_x <= '0; req.vel_y <= '0; req.vel_z <= '0;
      steps_cfg = 20; dt_cfg = 328; g_cfg = 65536;
      loaded = 0; errors = 0; items_sent = 0; results_seen = 0; runs_done = 0;
      no_idle = 0; hold_off_req = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_defaults();
      test_single_body_long();
      test_mass_and_gravity_extremes();
      test_store_full();
      test_backpressure();
      test_random_runs();
      repeat (50) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         errors++;
      end
      $display("Loaded %0d bodies over %0d runs, checked %0d body results.",
               items_sent, runs_done, results_seen);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
